// File: hdl/pinger_bearing_calculator_assert.svh
// Assertion macros shared by the checker of the pinger bearing calculator.
// Needs a clock i_clk and an active-low synchronous reset i_rst_n in scope.
`ifndef PINGER_BEARING_CALCULATOR_ASSERT_SVH
`define PINGER_BEARING_CALCULATOR_ASSERT_SVH

// same-cycle implication, off during reset
`define PBC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define PBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define PBC_ASSERT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/pbc_pkg.sv
// Package of the pinger bearing calculator: widths, register codes,
// the front-end handoff struct and the CORDIC arctangent table.
`default_nettype none
package pbc_pkg;

    localparam int ANGLE_BITS_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    // datapath width inside the CORDIC: 34-bit operands, pre-rotation and gain headroom
    localparam int CORDIC_W = 36;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_A_X = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_A_Y = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_B_X = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_B_Y = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SEL = 3'd4;

    localparam logic [1:0] SEL_NONE = 2'd0;
    localparam logic [1:0] SEL_A    = 2'd1;
    localparam logic [1:0] SEL_B    = 2'd2;

    // atan(2^-i) in units of 2^-32 of a circle
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    // table entry rounded to an ab-bit circle
    function automatic logic [31:0] atan_entry(input int unsigned i, input int unsigned ab);
        logic [31:0] t;
        logic [32:0] r;
        int unsigned s;
        t = ATAN_TAB[i[4:0]];
        s = 32 - ab;
        if (s == 0) begin
            return t;
        end
        r = {1'b0, t} + (33'd1 << (s - 1));
        return 32'(r >> s);
    endfunction

    // front end to CORDIC handoff
    typedef struct packed {
        logic                       ok;   // a pinger is selected
        logic signed [CORDIC_W-1:0] bx;   // bearing vector x
        logic signed [CORDIC_W-1:0] by;   // bearing vector y
        logic signed [CORDIC_W-1:0] yx;   // yaw vector x (cos term)
        logic signed [CORDIC_W-1:0] yy;   // yaw vector y (sin term)
    } t_front;

endpackage
`default_nettype wire

// File: hdl/pbc_front.sv
// Front end: configuration registers, position difference and quaternion
// products (stage 1), yaw operand sums (stage 2). Uses pbc_pkg.
`default_nettype none
module pbc_front (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_en,
    input  wire                                 i_cfg_wr_en,
    input  wire        [pbc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire        [pbc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire signed [31:0]                   i_pos_x,
    input  wire signed [31:0]                   i_pos_y,
    input  wire signed [15:0]                   i_quat_w,
    input  wire signed [15:0]                   i_quat_x,
    input  wire signed [15:0]                   i_quat_y,
    input  wire signed [15:0]                   i_quat_z,
    output pbc_pkg::t_front                     o_front
);
    localparam int CW = pbc_pkg::CORDIC_W;

    logic signed [31:0] r_a_x, r_a_y, r_b_x, r_b_y;
    logic        [1:0]  r_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_x <= '0;
            r_a_y <= '0;
            r_b_x <= '0;
            r_b_y <= '0;
            r_sel <= pbc_pkg::SEL_A;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                pbc_pkg::REG_A_X: r_a_x <= i_cfg_data;
                pbc_pkg::REG_A_Y: r_a_y <= i_cfg_data;
                pbc_pkg::REG_B_X: r_b_x <= i_cfg_data;
                pbc_pkg::REG_B_Y: r_b_y <= i_cfg_data;
                pbc_pkg::REG_SEL: r_sel <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // stage 1
    logic signed [31:0] tgt_x, tgt_y;
    logic               sel_ok;
    logic signed [32:0] r_dx, r_dy;
    logic signed [31:0] r_wz, r_xy, r_yy, r_zz;
    logic               r_ok1;

    always_comb begin
        sel_ok = (r_sel == pbc_pkg::SEL_A) || (r_sel == pbc_pkg::SEL_B);
        tgt_x  = (r_sel == pbc_pkg::SEL_B) ? r_b_x : r_a_x;
        tgt_y  = (r_sel == pbc_pkg::SEL_B) ? r_b_y : r_a_y;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx  <= $signed({tgt_x[31], tgt_x}) - $signed({i_pos_x[31], i_pos_x});
            r_dy  <= $signed({tgt_y[31], tgt_y}) - $signed({i_pos_y[31], i_pos_y});
            r_wz  <= i_quat_w * i_quat_z;
            r_xy  <= i_quat_x * i_quat_y;
            r_yy  <= i_quat_y * i_quat_y;
            r_zz  <= i_quat_z * i_quat_z;
            r_ok1 <= sel_ok;
        end
    end

    // stage 2: siny = 2(wz+xy), cosy = 2^28 - 2(yy+zz)
    logic signed [CW-1:0] n_sin, n_cos;
    pbc_pkg::t_front      r_front;

    always_comb begin
        n_sin = (CW'(r_wz) + CW'(r_xy)) <<< 1;
        n_cos = (CW'(1) <<< 28) - ((CW'(r_yy) + CW'(r_zz)) <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_front.ok <= r_ok1;
            r_front.bx <= CW'(r_dx);
            r_front.by <= CW'(r_dy);
            r_front.yx <= n_cos;
            r_front.yy <= n_sin;
        end
    end

    assign o_front = r_front;
endmodule
`default_nettype wire

// File: hdl/pbc_cordic.sv
// Pipelined vectoring CORDIC: atan2(y, x) as a binary angle, one stage for
// the half-turn pre-rotation and one per step. Uses pbc_pkg.
`default_nettype none
module pbc_cordic #(
    parameter int W     = pbc_pkg::CORDIC_W,
    parameter int AB    = pbc_pkg::ANGLE_BITS_DEF,
    parameter int STEPS = pbc_pkg::CORDIC_STEPS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_en,
    input  wire signed [W-1:0]  i_x,
    input  wire signed [W-1:0]  i_y,
    output logic       [AB-1:0] o_angle
);
    logic signed [W-1:0]  r_x    [STEPS+1];
    logic signed [W-1:0]  r_y    [STEPS+1];
    logic        [AB-1:0] r_z    [STEPS+1];
    logic                 r_zero [STEPS+1];

    // left half-plane: rotate by pi, start at half a circle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (i_x[W-1]) begin
                r_x[0] <= -i_x;
                r_y[0] <= -i_y;
                r_z[0] <= {1'b1, {(AB-1){1'b0}}};
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        localparam logic [AB-1:0] TAB = AB'(pbc_pkg::atan_entry(i, AB));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[i+1] <= r_zero[i];
                if (!r_y[i][W-1]) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + TAB;
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - TAB;
                end
            end
        end
    end

    assign o_angle = r_zero[STEPS] ? '0 : r_z[STEPS];
endmodule
`default_nettype wire

// File: hdl/pinger_bearing_calculator.sv
// Path: front-end stages, CORDIC pre-rotation and step stages, then the output register.
// Throughput: one beat per cycle; the CORDIC pipelines advance together and
// hold as a whole only while the output register is full and not taken.
// Reset (synchronous, active low): valid bits cleared, pinger positions 0,
// pinger A selected.
`default_nettype none
module pinger_bearing_calculator #(
    parameter int ANGLE_BITS   = pbc_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = pbc_pkg::CORDIC_STEPS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // config write port
    input  wire                                 i_cfg_wr_en,
    input  wire        [pbc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire        [pbc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // pose in
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire        [127:0]                  s_axis_tdata,  // pos_x, pos_y, quat_w, quat_x, quat_y, quat_z
    // headings out
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    output logic       [31:0]                   m_axis_tdata,  // world bearing, bearing minus yaw
    output logic                                m_axis_tuser   // heading_valid
);
    localparam int CW = pbc_pkg::CORDIC_W;
    // front end (2) + pre-rotation (1) + steps
    localparam int DEPTH = CORDIC_STEPS + 3;

    // Global advance: the whole pipe moves unless a result sits unclaimed.
    logic en;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    pbc_pkg::t_front front;

    pbc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_pos_x     (s_axis_tdata[31:0]),
        .i_pos_y     (s_axis_tdata[63:32]),
        .i_quat_w    (s_axis_tdata[79:64]),
        .i_quat_x    (s_axis_tdata[95:80]),
        .i_quat_y    (s_axis_tdata[111:96]),
        .i_quat_z    (s_axis_tdata[127:112]),
        .o_front     (front)
    );

    logic [ANGLE_BITS-1:0] bearing, yaw;

    pbc_cordic #(.W(CW), .AB(ANGLE_BITS), .STEPS(CORDIC_STEPS)) u_bearing (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_x     (front.bx),
        .i_y     (front.by),
        .o_angle (bearing)
    );

    pbc_cordic #(.W(CW), .AB(ANGLE_BITS), .STEPS(CORDIC_STEPS)) u_yaw (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_x     (front.yx),
        .i_y     (front.yy),
        .o_angle (yaw)
    );

    // valid line over every stage; select flag rides with the CORDIC stages
    logic r_vld [DEPTH];
    logic r_ok  [DEPTH-2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= s_axis_tvalid;
            for (int k = 1; k < DEPTH; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ok[0] <= front.ok;
            for (int k = 1; k < DEPTH-2; k++) r_ok[k] <= r_ok[k-1];
        end
    end

    // relative heading wraps modulo the circle
    logic [ANGLE_BITS-1:0] rel;
    logic [15:0]           abs16, rel16;
    assign rel = bearing - yaw;

    if (ANGLE_BITS >= 16) begin : g_top16
        assign abs16 = bearing[ANGLE_BITS-1 -: 16];
        assign rel16 = rel[ANGLE_BITS-1 -: 16];
    end else begin : g_widen
        assign abs16 = {bearing, {(16-ANGLE_BITS){1'b0}}};
        assign rel16 = {rel, {(16-ANGLE_BITS){1'b0}}};
    end

    // output register
    logic [31:0] r_out_data;
    logic        r_out_user;
    logic        r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_vld[DEPTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_user <= r_ok[DEPTH-3];
            r_out_data <= r_ok[DEPTH-3] ? {rel16, abs16} : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;
endmodule
`default_nettype wire

// File: hdl/pbc_checker.sv
// Port-level checker for the pinger bearing calculator, bound to the top.
// Uses the macros of pinger_bearing_calculator_assert.svh.
`default_nettype none
`include "pinger_bearing_calculator_assert.svh"
module pbc_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [31:0] m_axis_tdata,
    input wire        m_axis_tuser
);
    `PBC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "out beat dropped while stalled")
    `PBC_ASSERT_NOW(a_invalid_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 32'd0, "headings not zero without pinger")
    `PBC_ASSERT_NOW(a_ready_when_empty, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")
    `PBC_ASSERT_ALWAYS(a_reset_empty, !i_rst_n, !m_axis_tvalid, "output valid right after reset")
endmodule

bind pinger_bearing_calculator pbc_checker u_pbc_checker (.*);
`default_nettype wire

// File: tb/pinger_bearing_calculator_tb.sv
// Self-checking bench for the pinger bearing calculator: pose beats in, heading beats out.
// Needs pbc_pkg and pinger_bearing_calculator; the CORDIC bearing and yaw are predicted here.
`default_nettype none
module pinger_bearing_calculator_tb;

    localparam int LATENCY     = pbc_pkg::CORDIC_STEPS_DEF + 4;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] qw;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
    } t_pose;

    typedef struct packed {
        logic [15:0] abs_hdg;
        logic [15:0] rel_hdg;
        logic        hdg_ok;
    } t_heading;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [2:0]  i_cfg_addr = '0;
    logic [31:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;

    pinger_bearing_calculator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow registers
    logic signed [31:0] ping_ax, ping_ay, ping_bx, ping_by;
    logic [1:0]         ping_sel;

    t_heading heading_q[$];
    int  mismatches = 0;
    int  beats_in = 0, beats_out = 0;
    int  cycles = 0;
    int  send_idle_pct = 0, recv_idle_pct = 0;

    // vectoring CORDIC atan2, 16-bit circle
    function automatic logic [15:0] cordic_angle(longint y, longint x);
        logic [15:0] z;
        longint xs, ys, t;
        z = '0;
        if (x == 0 && y == 0) return 16'd0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 16'h8000;
        end
        for (int i = 0; i < pbc_pkg::CORDIC_STEPS_DEF; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            t = (pbc_pkg::ATAN_TAB[i] + 32'h8000) >> 16;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + t[15:0];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - t[15:0];
            end
        end
        return z;
    endfunction

    function automatic t_heading predict_heading(t_pose p);
        t_heading h;
        longint tx, ty, sn, cs;
        logic [15:0] brg, yaw;
        h = '0;
        if (ping_sel == pbc_pkg::SEL_A) begin
            tx = ping_ax;
            ty = ping_ay;
        end else if (ping_sel == pbc_pkg::SEL_B) begin
            tx = ping_bx;
            ty = ping_by;
        end else begin
            return h;
        end
        brg = cordic_angle(ty - longint'(p.pos_y), tx - longint'(p.pos_x));
        sn  = 2 * (longint'(p.qw) * p.qz + longint'(p.qx) * p.qy);
        cs  = (longint'(1) << 28) - 2 * (longint'(p.qy) * p.qy + longint'(p.qz) * p.qz);
        yaw = cordic_angle(sn, cs);
        h.abs_hdg = brg;
        h.rel_hdg = brg - yaw;
        h.hdg_ok  = 1'b1;
        return h;
    endfunction

    // cycle count, timeout, receiver stall
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d headings pending", cycles, heading_q.size());
            $display("status: fail");
            $finish;
        end
    end

    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    // result checker
    always @(posedge i_clk) begin
        t_heading exp_h;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            beats_out <= beats_out + 1;
            if (heading_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected heading beat %h/%b", m_axis_tdata, m_axis_tuser);
            end else begin
                exp_h = heading_q.pop_front();
                if (m_axis_tdata[15:0] !== exp_h.abs_hdg || m_axis_tdata[31:16] !== exp_h.rel_hdg
                        || m_axis_tuser !== exp_h.hdg_ok) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp abs %h rel %h ok %b, got abs %h rel %h ok %b",
                                 exp_h.abs_hdg, exp_h.rel_hdg, exp_h.hdg_ok,
                                 m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser);
                end
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        case (idx)
            pbc_pkg::REG_A_X: ping_ax  = val;
            pbc_pkg::REG_A_Y: ping_ay  = val;
            pbc_pkg::REG_B_X: ping_bx  = val;
            pbc_pkg::REG_B_Y: ping_by  = val;
            pbc_pkg::REG_SEL: ping_sel = val[1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // one pose beat; valid held high when the next beat follows straight on
    task automatic send_pose(t_pose p);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {p.qz, p.qy, p.qx, p.qw, p.pos_y, p.pos_x};
        do @(posedge i_clk); while (!s_axis_tready);
        heading_q.push_back(predict_heading(p));
        beats_in++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        wait (heading_q.size() == 0);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_quat(bit extreme);
        if (extreme) return $urandom_range(1) ? -16'sd32768 : 16'sd16384;
        return $signed(16'($urandom_range(32768))) - 16'sd16384;
    endfunction

    function automatic t_pose rand_pose();
        t_pose p;
        p.pos_x = ($urandom_range(3) == 0) ? $urandom : $signed($urandom_range(2000000)) - 1000000;
        p.pos_y = ($urandom_range(3) == 0) ? $urandom : $signed($urandom_range(2000000)) - 1000000;
        p.qw = rand_quat($urandom_range(15) == 0);
        p.qx = rand_quat($urandom_range(15) == 0);
        p.qy = rand_quat($urandom_range(15) == 0);
        p.qz = rand_quat($urandom_range(15) == 0);
        return p;
    endfunction

    // extremes, zero vector, half turn, raw quaternion corners
    task automatic test_directed();
        t_pose p;
        write_reg(pbc_pkg::REG_A_X, 32'sd0);
        write_reg(pbc_pkg::REG_A_Y, 32'sd0);
        p = '{0, 0, 16'sd16384, 0, 0, 0};                 // zero bearing vector
        send_pose(p);
        p = '{32'sd65536, 0, 16'sd16384, 0, 0, 0};        // pinger straight behind
        send_pose(p);
        p = '{0, 32'sd65536, 0, 0, 0, 16'sd16384};        // yaw pi
        send_pose(p);
        p = '{32'h7fffffff, 32'h80000000, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768};
        send_pose(p);
        p = '{32'h80000000, 32'h7fffffff, 16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384};
        send_pose(p);
        p = '{32'hffffffff, 32'hffffffff, -16'sd1, 16'sd1, -16'sd16384, 16'sd16384};
        send_pose(p);
        p = '{32'h55555555, 32'haaaaaaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa};
        send_pose(p);
        drain();
        write_reg(pbc_pkg::REG_A_X, 32'h7fffffff);
        write_reg(pbc_pkg::REG_A_Y, 32'h80000000);
        p = '{32'h80000000, 32'h7fffffff, 16'sd16384, 0, 0, 0};
        send_pose(p);
        drain();
        write_reg(pbc_pkg::REG_B_X, 32'h80000000);
        write_reg(pbc_pkg::REG_B_Y, 32'h7fffffff);
        write_reg(pbc_pkg::REG_SEL, pbc_pkg::SEL_B);
        p = '{32'h7fffffff, 32'h80000000, 0, 16'sd16384, 0, 0};
        send_pose(p);
        send_pose(rand_pose());
        drain();
        write_reg(pbc_pkg::REG_SEL, pbc_pkg::SEL_NONE);
        send_pose(rand_pose());
        drain();
        write_reg(pbc_pkg::REG_SEL, 2'd3);                 // unused selector code
        send_pose(rand_pose());
        drain();
        write_reg(3'd5, 32'hffffffff);                     // unmapped index, ignored
        write_reg(3'd7, 32'h0);
        write_reg(pbc_pkg::REG_SEL, pbc_pkg::SEL_A);
        send_pose(rand_pose());
        drain();
    endtask

    // random poses across several pinger setups and idle mixes
    task automatic test_random(int n_items, int snd, int rcv);
        send_idle_pct = snd;
        recv_idle_pct = rcv;
        for (int k = 0; k < n_items; k++) begin
            if (k % 40 == 0) begin
                drain();
                write_reg(pbc_pkg::REG_A_X, $urandom);
                write_reg(pbc_pkg::REG_A_Y, $signed($urandom_range(2000000)) - 1000000);
                write_reg(pbc_pkg::REG_B_X, $signed($urandom_range(2000000)) - 1000000);
                write_reg(pbc_pkg::REG_B_Y, $urandom);
                write_reg(pbc_pkg::REG_SEL, ($urandom_range(9) == 0) ? pbc_pkg::SEL_NONE
                          : ($urandom_range(1) ? pbc_pkg::SEL_A : pbc_pkg::SEL_B));
            end
            send_pose(rand_pose());
        end
        drain();
    endtask

    initial begin
        ping_ax = 0; ping_ay = 0; ping_bx = 0; ping_by = 0; ping_sel = pbc_pkg::SEL_A;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(160, 27, 81);
        test_random(160, 81, 27);
        test_random(130, 0, 0);
        $display("sent %0d poses, checked %0d heading beats, %0d mismatches",
                 beats_in, beats_out, mismatches);
        $display("covered: both pingers, no pinger, field extremes, three idle mixes");
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
`default_nettype wire
